// ----- src/whmm_pkg.sv -----
// ----------------------------------------------------------------------------
// whmm_pkg
// Shared types and constants for the windowed history min/max unit.
// ----------------------------------------------------------------------------
package whmm_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR_RD,
        S_CLR_WAIT,
        S_CLR_SET,
        S_ADD_WR,
        S_DROP_RD,
        S_DROP_CMP,
        S_SCAN_INIT,
        S_SCAN,
        S_THR_CHK,
        S_THR_WAIT,
        S_FIN
    } t_state;

    localparam logic        REQ_ADD = 1'b0;
    localparam logic        REQ_CLR = 1'b1;

    localparam logic [1:0]  CFG_WINDOW = 2'd0;
    localparam logic [1:0]  CFG_GROWTH = 2'd1;
    localparam logic [1:0]  CFG_MINSMP = 2'd2;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic [47:0] THR_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [10:0] MAX_PASSES = 11'd1024;

    localparam logic [15:0] WF_RESET = 16'd32768;
    localparam logic [31:0] GF_RESET = 32'd1121280437;
    localparam logic [4:0]  MS_RESET = 5'd4;

endpackage

// ----- src/whmm_ring_mem.sv -----
// ----------------------------------------------------------------------------
// whmm_ring_mem
// Ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module whmm_ring_mem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- src/whmm_thr_unit.sv -----
// ----------------------------------------------------------------------------
// whmm_thr_unit
// One threshold growth pass: base + (t - base) * growth / 2^30, at least
// t + 1, saturated. Multiply split in two 48x16 halves.
// ----------------------------------------------------------------------------
module whmm_thr_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_t,
    input  logic [31:0] i_base,
    input  logic [31:0] i_gf,
    output logic        o_done,
    output logic [47:0] o_nt
);

    logic [2:0]  r_ph;
    logic [47:0] r_t;
    logic [47:0] r_diff;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [49:0] r_sc;
    logic [47:0] w_base48;
    logic [79:0] w_full;
    logic [50:0] w_sum;
    logic [47:0] w_nt;
    logic [47:0] w_nt_fix;

    assign w_base48 = {i_base, 16'd0};
    assign w_full   = {r_a, 16'd0} + {16'd0, r_b};
    assign w_sum    = {3'd0, w_base48} + {1'b0, r_sc};
    assign w_nt     = (w_sum > {3'd0, whmm_pkg::THR_MAX}) ? whmm_pkg::THR_MAX : w_sum[47:0];
    assign w_nt_fix = (w_nt > r_t) ? w_nt :
                      ((r_t == whmm_pkg::THR_MAX) ? whmm_pkg::THR_MAX : r_t + 48'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 3'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_ph)
                3'd0: begin
                    if (i_start) begin
                        r_ph <= 3'd1;
                    end
                end
                3'd4: begin
                    r_ph   <= 3'd0;
                    o_done <= 1'b1;
                end
                default: begin
                    r_ph <= r_ph + 3'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph == 3'd0 && i_start) begin
            r_t    <= i_t;
            r_diff <= (i_t > w_base48) ? i_t - w_base48 : 48'd0;
        end
        if (r_ph == 3'd1) begin
            r_a <= 64'(r_diff) * 64'(i_gf[31:16]);
        end
        if (r_ph == 3'd2) begin
            r_b <= 64'(r_diff) * 64'(i_gf[15:0]);
        end
        if (r_ph == 3'd3) begin
            r_sc <= w_full[79:30];
        end
        if (r_ph == 3'd4) begin
            o_nt <= w_nt_fix;
        end
    end

endmodule

// ----- src/windowed_history_min_max_unit.sv -----
// ----------------------------------------------------------------------------
// windowed_history_min_max_unit
// Ring of (iteration, value) pairs with windowed min/max and geometric
// add threshold.
//
//   channel | signals                                   | dir
//   in      | i_in_valid/o_in_ready, req, iter, value   | in
//   out     | o_out_valid/i_out_ready, min, max, flags  | out
//   cfg     | i_cfg_we, i_cfg_idx, i_cfg_wdata          | in
//
// One word at a time. A refused add goes straight to the result. A clear
// takes the newest iteration as base when the ring is not empty. An accepted
// add writes, drops old entries, scans for min/max, then runs threshold passes.
// Synchronous active-low reset; ring contents are not cleared.
// A stalled result holds the unit in its final state until taken.
// ----------------------------------------------------------------------------
module windowed_history_min_max_unit #(
    parameter int SAMPLES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic [31:0]        i_iteration,
    input  logic signed [31:0] i_sample_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_window_min,
    output logic signed [31:0] o_window_max,
    output logic               o_ready_res,
    output logic               o_accepted,
    output logic [4:0]         o_sample_count,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_wdata
);

    localparam int IW = $clog2(SAMPLES);
    localparam int CW = $clog2(SAMPLES + 2);

    function automatic logic [IW-1:0] f_wrap(input logic [IW:0] s);
        logic [IW:0] d;
        d = s - (IW+1)'(SAMPLES);
        return (s >= (IW+1)'(SAMPLES)) ? d[IW-1:0] : s[IW-1:0];
    endfunction

    whmm_pkg::t_state r_state, n_state;

    logic [IW-1:0]      r_oldest;
    logic [CW-1:0]      r_held;
    logic [31:0]        r_base;
    logic [48:0]        r_thr;
    logic signed [31:0] r_cmin, r_cmax;
    logic [15:0]        r_wf;
    logic [31:0]        r_gf;
    logic [4:0]         r_ms;
    logic [31:0]        r_it;
    logic signed [31:0] r_val;
    logic               r_acc;
    logic signed [50:0] r_prod;
    logic [CW-1:0]      r_k;
    logic [IW-1:0]      r_ptr;
    logic               r_rv;
    logic [10:0]        r_passes;

    logic               w_accept, w_take, w_drop, w_scan_done, w_thr_done;
    logic               w_mem_we, w_thr_start;
    logic [IW-1:0]      w_waddr, w_it_raddr;
    logic [31:0]        w_it_rd, w_val_rd;
    logic [47:0]        w_thr_nt;
    logic [47:0]        w_itq;
    logic signed [32:0] w_od, w_span;
    logic signed [50:0] w_odq;
    logic signed [17:0] w_keep;

    assign o_in_ready = (r_state == whmm_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_itq      = {r_it, 16'd0};
    assign w_take     = (r_held == '0) || ({1'b0, i_iteration, 16'd0} >= r_thr);

    assign w_od   = $signed({1'b0, w_it_rd}) - $signed({1'b0, r_base});
    assign w_odq  = {{2{w_od[32]}}, w_od, 16'd0};
    assign w_span = $signed({1'b0, r_it}) - $signed({1'b0, r_base});
    assign w_keep = $signed({1'b0, 17'(17'd65536 - {1'b0, r_wf})});
    assign w_drop = (32'(r_held) > SAMPLES) || (w_odq < r_prod);
    assign w_scan_done = (r_k == r_held) && !r_rv;

    whmm_ring_mem #(.WIDTH(32), .DEPTH(SAMPLES)) u_it_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (r_it),
        .i_raddr (w_it_raddr),
        .o_rdata (w_it_rd)
    );

    whmm_ring_mem #(.WIDTH(32), .DEPTH(SAMPLES)) u_val_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (r_val),
        .i_raddr (r_ptr),
        .o_rdata (w_val_rd)
    );

    whmm_thr_unit u_thr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_thr_start),
        .i_t     (r_thr[47:0]),
        .i_base  (r_base),
        .i_gf    (r_gf),
        .o_done  (w_thr_done),
        .o_nt    (w_thr_nt)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            whmm_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == whmm_pkg::REQ_CLR) begin
                        n_state = (r_held != '0) ? whmm_pkg::S_CLR_RD : whmm_pkg::S_CLR_SET;
                    end else begin
                        n_state = w_take ? whmm_pkg::S_ADD_WR : whmm_pkg::S_FIN;
                    end
                end
            end
            whmm_pkg::S_CLR_RD:   n_state = whmm_pkg::S_CLR_WAIT;
            whmm_pkg::S_CLR_WAIT: n_state = whmm_pkg::S_CLR_SET;
            whmm_pkg::S_CLR_SET:  n_state = whmm_pkg::S_FIN;
            whmm_pkg::S_ADD_WR:   n_state = whmm_pkg::S_DROP_RD;
            whmm_pkg::S_DROP_RD: begin
                n_state = (r_held == '0) ? whmm_pkg::S_SCAN_INIT : whmm_pkg::S_DROP_CMP;
            end
            whmm_pkg::S_DROP_CMP: begin
                n_state = w_drop ? whmm_pkg::S_DROP_RD : whmm_pkg::S_SCAN_INIT;
            end
            whmm_pkg::S_SCAN_INIT: n_state = whmm_pkg::S_SCAN;
            whmm_pkg::S_SCAN: begin
                if (w_scan_done) begin
                    n_state = whmm_pkg::S_THR_CHK;
                end
            end
            whmm_pkg::S_THR_CHK: begin
                if (r_thr > {1'b0, w_itq} || r_passes >= whmm_pkg::MAX_PASSES) begin
                    n_state = whmm_pkg::S_FIN;
                end else begin
                    n_state = whmm_pkg::S_THR_WAIT;
                end
            end
            whmm_pkg::S_THR_WAIT: begin
                if (w_thr_done) begin
                    n_state = whmm_pkg::S_THR_CHK;
                end
            end
            whmm_pkg::S_FIN: begin
                if (!o_out_valid || i_out_ready) begin
                    n_state = whmm_pkg::S_IDLE;
                end
            end
            default: n_state = whmm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_mem_we    = 1'b0;
        w_waddr     = f_wrap({1'b0, r_oldest} + (IW+1)'(r_held));
        w_it_raddr  = r_oldest;
        w_thr_start = 1'b0;
        case (r_state)
            whmm_pkg::S_ADD_WR: w_mem_we = 1'b1;
            whmm_pkg::S_CLR_RD: begin
                w_it_raddr = f_wrap({1'b0, r_oldest} + (IW+1)'(r_held) - (IW+1)'(1));
            end
            whmm_pkg::S_THR_CHK: begin
                w_thr_start = !(r_thr > {1'b0, w_itq}) && (r_passes < whmm_pkg::MAX_PASSES);
            end
            default: w_mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= whmm_pkg::S_IDLE;
            r_oldest    <= '0;
            r_held      <= '0;
            r_base      <= '0;
            r_thr       <= 49'd65536;
            r_cmin      <= whmm_pkg::VAL_MIN;
            r_cmax      <= whmm_pkg::VAL_MAX;
            r_wf        <= whmm_pkg::WF_RESET;
            r_gf        <= whmm_pkg::GF_RESET;
            r_ms        <= whmm_pkg::MS_RESET;
            r_rv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    whmm_pkg::CFG_WINDOW: r_wf <= i_cfg_wdata[15:0];
                    whmm_pkg::CFG_GROWTH: r_gf <= i_cfg_wdata;
                    whmm_pkg::CFG_MINSMP: r_ms <= i_cfg_wdata[4:0];
                    default: r_ms <= r_ms;
                endcase
            end
            if (o_out_valid && i_out_ready && r_state != whmm_pkg::S_FIN) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                whmm_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_it   <= i_iteration;
                        r_val  <= i_sample_value;
                        r_acc  <= (i_req_type == whmm_pkg::REQ_ADD) && w_take;
                        r_passes <= '0;
                    end
                end
                whmm_pkg::S_CLR_WAIT: r_base <= w_it_rd;
                whmm_pkg::S_CLR_SET: begin
                    r_oldest <= '0;
                    r_held   <= '0;
                    r_thr    <= {1'b0, r_base, 16'd0} + 49'd65536;
                    r_cmin   <= whmm_pkg::VAL_MIN;
                    r_cmax   <= whmm_pkg::VAL_MAX;
                end
                whmm_pkg::S_ADD_WR: begin
                    r_held <= r_held + CW'(1);
                    r_prod <= 51'(w_span) * 51'(w_keep);
                end
                whmm_pkg::S_DROP_CMP: begin
                    if (w_drop) begin
                        r_oldest <= f_wrap({1'b0, r_oldest} + (IW+1)'(1));
                        r_held   <= r_held - CW'(1);
                    end
                end
                whmm_pkg::S_SCAN_INIT: begin
                    r_k    <= '0;
                    r_ptr  <= r_oldest;
                    r_rv   <= 1'b0;
                    r_cmin <= whmm_pkg::VAL_MAX;
                    r_cmax <= whmm_pkg::VAL_MIN;
                end
                whmm_pkg::S_SCAN: begin
                    if (r_k != r_held) begin
                        r_ptr <= f_wrap({1'b0, r_ptr} + (IW+1)'(1));
                        r_k   <= r_k + CW'(1);
                        r_rv  <= 1'b1;
                    end else begin
                        r_rv  <= 1'b0;
                    end
                    if (r_rv) begin
                        if ($signed(w_val_rd) < r_cmin) r_cmin <= $signed(w_val_rd);
                        if ($signed(w_val_rd) > r_cmax) r_cmax <= $signed(w_val_rd);
                    end
                end
                whmm_pkg::S_THR_CHK: begin
                    if (!(r_thr > {1'b0, w_itq})) begin
                        if (r_passes >= whmm_pkg::MAX_PASSES) begin
                            r_thr <= {1'b0, w_itq} + 49'd1;
                        end else begin
                            r_passes <= r_passes + 11'd1;
                        end
                    end
                end
                whmm_pkg::S_THR_WAIT: begin
                    if (w_thr_done) begin
                        r_thr <= {1'b0, w_thr_nt};
                    end
                end
                whmm_pkg::S_FIN: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid    <= 1'b1;
                        o_ready_res    <= 32'(r_held) >= 32'(r_ms);
                        o_window_min   <= (32'(r_held) >= 32'(r_ms)) ? r_cmin : whmm_pkg::VAL_MIN;
                        o_window_max   <= (32'(r_held) >= 32'(r_ms)) ? r_cmax : whmm_pkg::VAL_MAX;
                        o_accepted     <= r_acc;
                        o_sample_count <= 5'(r_held);
                    end
                end
                default: r_rv <= 1'b0;
            endcase
        end
    end

endmodule
